// ===== hw/rtl/bltd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bltd_pkg
// Types, codes and limits shared by the bit-coded lambda term token decoder.
// ----------------------------------------------------------------------------
package bltd_pkg;

  localparam int MAX_VAR_INDEX = 65535;
  localparam int MAX_PENDING   = 65535;
  localparam int VAR_W         = 16;
  localparam int ONES_W        = 17;
  localparam int PEND_W        = 16;
  localparam int MAX_TOKENS    = 4;

  // A run of ones stops counting two above the largest index.
  localparam logic [ONES_W-1:0] ONES_SAT = ONES_W'(MAX_VAR_INDEX + 2);

  typedef enum logic [2:0] {
    PH_TAG0,
    PH_TAG1,
    PH_TAG2,
    PH_ONES,
    PH_SEL,
    PH_IDX
  } phase_t;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_ABS = 2'd0;
  localparam kind_t KIND_APP = 2'd1;
  localparam kind_t KIND_VAR = 2'd2;
  localparam kind_t KIND_REF = 2'd3;

  typedef struct packed {
    phase_t              phase;
    logic [1:0]          sel;
    logic [ONES_W-1:0]   ones;
    logic [6:0]          bit_pos;
    logic [63:0]         accum;
    logic [PEND_W-1:0]   pending;
    logic [31:0]         entry;
  } dec_state_t;

  localparam dec_state_t STATE_RESET = '{
    phase:   PH_TAG0,
    sel:     2'd0,
    ones:    '0,
    bit_pos: 7'd0,
    accum:   64'd0,
    pending: PEND_W'(1),
    entry:   32'd0
  };

  typedef struct packed {
    kind_t       kind;
    logic [31:0] value;
    logic        done;
    logic [31:0] entry_number;
    logic        err;
    logic        last;
  } token_t;

endpackage

// ===== hw/rtl/bltd_byte_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bltd_byte_if
// Input channel: one entry data byte per beat.
// ----------------------------------------------------------------------------
interface bltd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

// ===== hw/rtl/bltd_token_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bltd_token_if
// Output channel: one decoded token per beat.
// ----------------------------------------------------------------------------
interface bltd_token_if;
  logic        valid;
  logic        ready;
  logic [1:0]  token_kind;
  logic [31:0] token_value;
  logic        entry_done;
  logic [31:0] entry_number;
  logic        decode_error;
  logic        last;

  modport source (output valid, output token_kind, output token_value, output entry_done,
                  output entry_number, output decode_error, output last, input ready);
  modport sink (input valid, input token_kind, input token_value, input entry_done,
                input entry_number, input decode_error, input last, output ready);
endinterface

// ===== hw/rtl/bltd_cfg_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bltd_cfg_if
// Configuration write channel for the entry count register.
// ----------------------------------------------------------------------------
interface bltd_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] entry_count;

  modport source (output valid, output entry_count, input ready);
  modport sink (input valid, input entry_count, output ready);
endinterface

// ===== hw/rtl/bltd_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bltd_decode
// Walks the eight bits of one byte through the prefix code and returns the
// next decode state and up to four tokens.
// ----------------------------------------------------------------------------
module bltd_decode (
  input  bltd_pkg::dec_state_t            st,
  input  logic [7:0]                      data_byte,
  input  logic [31:0]                     entry_count,
  output bltd_pkg::dec_state_t            st_next,
  output bltd_pkg::token_t [3:0]          toks,
  output logic [2:0]                      count
);
  import bltd_pkg::*;

  always_comb begin : walk
    dec_state_t         s;
    token_t [3:0]       tk;
    logic [2:0]         n;
    logic               stop;
    logic               b;
    logic               emit;
    logic               err;
    logic               done;
    kind_t              kind;
    logic [VAR_W-1:0]   vval;
    logic [ONES_W-1:0]  idx;
    logic [63:0]        cap;
    logic [33:0]        diff;
    logic               ref_err;
    logic [31:0]        ref_val;

    s       = st;
    tk      = '0;
    n       = 3'd0;
    stop    = 1'b0;
    b       = 1'b0;
    emit    = 1'b0;
    err     = 1'b0;
    done    = 1'b0;
    kind    = KIND_ABS;
    vval    = '0;
    idx     = '0;
    cap     = '0;

    for (int i = 7; i >= 0; i--) begin
      if (!stop) begin
        b    = data_byte[3'(i)];
        emit = 1'b0;
        err  = 1'b0;
        vval = '0;
        kind = KIND_ABS;
        case (s.phase)
          PH_TAG1: begin
            if (b) begin
              s.phase = PH_TAG2;
            end else begin
              emit = 1'b1;
              kind = KIND_APP;
            end
          end
          PH_TAG2: begin
            if (b) begin
              s.phase   = PH_SEL;
              s.sel     = 2'd0;
              s.bit_pos = 7'd0;
            end else begin
              emit = 1'b1;
              kind = KIND_ABS;
            end
          end
          PH_ONES: begin
            if (b) begin
              if (s.ones < ONES_SAT) begin
                s.ones = s.ones + 1'b1;
              end
            end else begin
              idx = s.ones - 1'b1;
              if (idx > ONES_W'(MAX_VAR_INDEX)) begin
                vval = VAR_W'(MAX_VAR_INDEX);
                err  = 1'b1;
              end else begin
                vval = idx[VAR_W-1:0];
              end
              s.ones = '0;
              emit   = 1'b1;
              kind   = KIND_VAR;
            end
          end
          PH_SEL: begin
            s.sel     = {s.sel[0], b};
            s.bit_pos = s.bit_pos + 7'd1;
            if (s.bit_pos >= 7'd2) begin
              s.accum   = 64'd0;
              s.bit_pos = 7'd0;
              s.phase   = PH_IDX;
            end
          end
          PH_IDX: begin
            s.accum[s.bit_pos[5:0]] = s.accum[s.bit_pos[5:0]] | b;
            s.bit_pos = s.bit_pos + 7'd1;
            if (s.bit_pos >= (7'd8 << s.sel)) begin
              // normalize once after the walk; keep the index seen here
              cap       = s.accum;
              s.bit_pos = 7'd0;
              emit      = 1'b1;
              kind      = KIND_REF;
            end
          end
          default: begin
            if (b) begin
              s.ones  = ONES_W'(1);
              s.phase = PH_ONES;
            end else begin
              s.phase = PH_TAG1;
            end
          end
        endcase

        if (emit) begin
          if (kind == KIND_APP) begin
            if (s.pending >= PEND_W'(MAX_PENDING)) begin
              err = 1'b1;
            end else begin
              s.pending = s.pending + 1'b1;
            end
          end else if (kind == KIND_VAR || kind == KIND_REF) begin
            if (s.pending != '0) begin
              s.pending = s.pending - 1'b1;
            end
          end
          done = (s.pending == '0);
          tk[n[1:0]].kind         = kind;
          tk[n[1:0]].value        = {{(32 - VAR_W){1'b0}}, vval};
          tk[n[1:0]].done         = done;
          tk[n[1:0]].entry_number = s.entry;
          tk[n[1:0]].err          = err;
          tk[n[1:0]].last         = 1'b0;
          s.phase = PH_TAG0;
          if (done) begin
            s.pending = PEND_W'(1);
            s.entry   = s.entry + 32'd1;
          end
          n = n + 3'd1;
          // drop the rest of the byte after an entry ends or the slots fill
          if (done || n == 3'(MAX_TOKENS)) begin
            stop = 1'b1;
          end
        end
      end
    end

    // at most one reference fits in a byte
    diff    = {2'b00, entry_count} - {2'b00, cap[31:0]} - 34'd2;
    ref_err = (cap[63:32] != 32'd0) || diff[33];
    ref_val = ref_err ? 32'd0 : diff[31:0];
    for (int j = 0; j < MAX_TOKENS; j++) begin
      if (3'(j) < n && tk[j].kind == KIND_REF) begin
        tk[j].value = ref_val;
        tk[j].err   = ref_err;
      end
    end
    if (n != 3'd0) begin
      tk[2'(n - 3'd1)].last = 1'b1;
    end

    st_next = s;
    toks    = tk;
    count   = n;
  end

endmodule

// ===== hw/rtl/bit_lambda_term_token_decoder_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bit_lambda_term_token_decoder_unit
// A byte's first token is registered and offered in the cycle after its beat.
// Each byte yields 0..4 tokens into a 4-slot buffer; the token port moves
// one token per beat out of it, and a stalled token port holds back bytes.
// A byte is taken when the buffer is empty or hands out its final token.
// Reset (synchronous): decode state to STATE_RESET, entry_count = 1, buffer empty.
// ----------------------------------------------------------------------------
module bit_lambda_term_token_decoder_unit (
  input  logic          clk,
  input  logic          rst,
  bltd_byte_if.sink     bytes,
  bltd_token_if.source  tokens,
  bltd_cfg_if.sink      cfg
);
  import bltd_pkg::*;

  dec_state_t    st;
  dec_state_t    st_next;
  token_t [3:0]  dec_toks;
  logic [2:0]    dec_count;
  logic [31:0]   entry_count;

  token_t [3:0]  buf_toks;
  logic [2:0]    buf_cnt;
  logic [1:0]    rd_ptr;
  token_t        head;
  logic          take;
  logic          accept;

  bltd_decode u_decode (
    .st          (st),
    .data_byte   (bytes.data_byte),
    .entry_count (entry_count),
    .st_next     (st_next),
    .toks        (dec_toks),
    .count       (dec_count)
  );

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= 32'd1;
    end else if (cfg.valid) begin
      entry_count <= cfg.entry_count;
    end
  end

  assign head   = buf_toks[rd_ptr];
  assign take   = tokens.valid && tokens.ready;
  // take a new byte when the buffer is empty or its final token leaves now
  assign bytes.ready = (buf_cnt == 3'd0) || (buf_cnt == 3'd1 && tokens.ready);
  assign accept = bytes.valid && bytes.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      st      <= STATE_RESET;
      buf_cnt <= 3'd0;
      rd_ptr  <= 2'd0;
    end else if (accept) begin
      st      <= st_next;
      buf_cnt <= dec_count;
      rd_ptr  <= 2'd0;
    end else if (take) begin
      buf_cnt <= buf_cnt - 3'd1;
      rd_ptr  <= rd_ptr + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      buf_toks <= dec_toks;
    end
  end

  assign tokens.valid        = (buf_cnt != 3'd0);
  assign tokens.token_kind   = head.kind;
  assign tokens.token_value  = head.value;
  assign tokens.entry_done   = head.done;
  assign tokens.entry_number = head.entry_number;
  assign tokens.decode_error = head.err;
  assign tokens.last         = head.last;

endmodule

// ===== tb/bit_lambda_term_token_decoder_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bit_lambda_term_token_decoder_unit_tb
// Drives entry bytes into the token decoder and predicts every token it
// emits: kind, value, entry completion, entry number, error and last flag.
// Covers directed terms, entry_count extremes, multi-byte variables, nested
// applications, a long token stall and random well-formed, broken
// and noise byte streams, with random gaps on both channels.
// ----------------------------------------------------------------------------
module bit_lambda_term_token_decoder_unit_tb;
  import bltd_pkg::*;

  localparam int STALL_LIMIT    = 2000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int HOLD_CYCLES    = 300;
  localparam int RANDOM_BYTES   = 200;
  localparam int VAR_ONES_CAP   = MAX_VAR_INDEX + 2;
  localparam int VAR_RUN_BYTES  = 16;
  localparam int APP_RUN_BYTES  = 16;
  localparam int MAX_PRINTED    = 40;

  logic clk;
  logic rst;

  bltd_byte_if  bytes_if ();
  bltd_token_if tokens_if ();
  bltd_cfg_if   cfg_if ();

  bit_lambda_term_token_decoder_unit u_dut (
    .clk    (clk),
    .rst    (rst),
    .bytes  (bytes_if),
    .tokens (tokens_if),
    .cfg    (cfg_if)
  );

  // Predicted decoder state and register copy.
  dec_state_t  dec_st;
  logic [31:0] entry_count_cfg;

  token_t expected_tokens[$];
  token_t byte_tokens[$];
  logic   term_bits[$];

  int  mismatches;
  int  tokens_checked;
  int  bytes_sent;
  int  settings_used;
  int  quiet_cycles;
  int  stall_left;
  int  hold_req;
  bit  idle_en;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_en || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // ---------------- prediction ----------------

  function automatic logic emit_token(input kind_t kind, input logic [31:0] value,
                                      input logic err_in);
    token_t t;
    logic   err;
    err = err_in;
    if (kind == KIND_APP) begin
      if (dec_st.pending >= MAX_PENDING) err = 1'b1;
      else dec_st.pending = dec_st.pending + 1'b1;
    end else if (kind == KIND_VAR || kind == KIND_REF) begin
      if (dec_st.pending != 0) dec_st.pending = dec_st.pending - 1'b1;
    end
    t.kind         = kind;
    t.value        = value;
    t.done         = (dec_st.pending == 0);
    t.entry_number = dec_st.entry;
    t.err          = err;
    t.last         = 1'b0;
    byte_tokens.push_back(t);
    dec_st.phase = PH_TAG0;
    if (t.done) begin
      dec_st.pending = 1;
      dec_st.entry   = dec_st.entry + 1;
    end
    return t.done;
  endfunction

  function automatic void decode_byte(input logic [7:0] data);
    logic        bitv;
    logic        done;
    int          var_idx;
    logic        err;
    logic [31:0] ref_val;
    byte_tokens.delete();
    for (int i = 7; i >= 0; i--) begin
      bitv = data[i];
      done = 1'b0;
      case (dec_st.phase)
        PH_TAG1: begin
          if (bitv) dec_st.phase = PH_TAG2;
          else done = emit_token(KIND_APP, 32'd0, 1'b0);
        end
        PH_TAG2: begin
          if (bitv) begin
            dec_st.phase   = PH_SEL;
            dec_st.sel     = 2'd0;
            dec_st.bit_pos = 7'd0;
          end else begin
            done = emit_token(KIND_ABS, 32'd0, 1'b0);
          end
        end
        PH_ONES: begin
          if (bitv) begin
            if (dec_st.ones < VAR_ONES_CAP) dec_st.ones = dec_st.ones + 1'b1;
          end else begin
            var_idx = int'(dec_st.ones) - 1;
            err = 1'b0;
            if (var_idx > MAX_VAR_INDEX) begin
              var_idx = MAX_VAR_INDEX;
              err = 1'b1;
            end
            dec_st.ones = '0;
            done = emit_token(KIND_VAR, 32'(var_idx), err);
          end
        end
        PH_SEL: begin
          dec_st.sel     = {dec_st.sel[0], bitv};
          dec_st.bit_pos = dec_st.bit_pos + 1'b1;
          if (dec_st.bit_pos >= 7'd2) begin
            dec_st.accum   = 64'd0;
            dec_st.bit_pos = 7'd0;
            dec_st.phase   = PH_IDX;
          end
        end
        PH_IDX: begin
          if (dec_st.bit_pos < 7'd64) dec_st.accum[dec_st.bit_pos[5:0]] = bitv;
          dec_st.bit_pos = dec_st.bit_pos + 1'b1;
          if (dec_st.bit_pos >= (7'd8 << dec_st.sel)) begin
            ref_val = 32'd0;
            err = 1'b1;
            if (entry_count_cfg >= 32'd2 &&
                dec_st.accum <= {32'd0, entry_count_cfg} - 64'd2) begin
              ref_val = entry_count_cfg - dec_st.accum[31:0] - 32'd2;
              err = 1'b0;
            end
            dec_st.bit_pos = 7'd0;
            done = emit_token(KIND_REF, ref_val, err);
          end
        end
        default: begin
          if (bitv) begin
            dec_st.ones  = 1;
            dec_st.phase = PH_ONES;
          end else begin
            dec_st.phase = PH_TAG1;
          end
        end
      endcase
      // Drop the rest of the byte once the entry closes or the slots are full.
      if (done || byte_tokens.size() >= MAX_TOKENS) break;
    end
    if (byte_tokens.size() != 0) byte_tokens[byte_tokens.size() - 1].last = 1'b1;
    foreach (byte_tokens[i]) expected_tokens.push_back(byte_tokens[i]);
  endfunction

  // ---------------- term building ----------------

  function automatic void stage_field(input logic [63:0] v, input int n);
    for (int i = n - 1; i >= 0; i--) term_bits.push_back(v[i]);
  endfunction

  function automatic void stage_abs();
    stage_field(64'b010, 3);
  endfunction

  function automatic void stage_app();
    stage_field(64'b00, 2);
  endfunction

  function automatic void stage_var(input int k);
    repeat (k + 1) term_bits.push_back(1'b1);
    term_bits.push_back(1'b0);
  endfunction

  // Index bits go out least significant first.
  function automatic void stage_ref(input logic [1:0] sel, input logic [63:0] idx);
    int w;
    w = 8 << sel;
    stage_field(64'b011, 3);
    stage_field({62'd0, sel}, 2);
    for (int i = 0; i < w; i++) term_bits.push_back(idx[i]);
  endfunction

  function automatic logic [63:0] pick_ref_index();
    logic [63:0] ec;
    ec = {32'd0, entry_count_cfg};
    case ($urandom_range(0, 5))
      0: return 64'd0;
      1: return ec - 64'd2;
      2: return ec - 64'd1;
      3: return ec - 64'($urandom_range(2, 6));
      4: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic void stage_leaf();
    if ($urandom_range(0, 99) < 60) begin
      if ($urandom_range(0, 7) == 0) stage_var($urandom_range(8, 40));
      else stage_var($urandom_range(0, 5));
    end else begin
      stage_ref(2'($urandom_range(0, 3)), pick_ref_index());
    end
  endfunction

  // Prefix order: an application opens one more subterm, a leaf closes one.
  function automatic void stage_random_term(input int max_nodes);
    int open_terms;
    int nodes;
    int r;
    open_terms = 1;
    nodes = 0;
    while (open_terms > 0) begin
      r = $urandom_range(0, 99);
      if (nodes < max_nodes && r < 22) begin
        stage_abs();
      end else if (nodes < max_nodes && r < 50) begin
        stage_app();
        open_terms++;
      end else begin
        stage_leaf();
        open_terms--;
      end
      nodes++;
    end
  endfunction

  // ---------------- channel tasks ----------------

  task automatic send_byte(input logic [7:0] data);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      bytes_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    bytes_if.valid     <= 1'b1;
    bytes_if.data_byte <= data;
    do @(posedge clk); while (!bytes_if.ready);
    bytes_sent++;
    decode_byte(data);
  endtask

  // Pad the staged term to a byte boundary with random bits and send it.
  task automatic send_staged();
    logic [7:0] data;
    while (term_bits.size() % 8 != 0) term_bits.push_back(1'($urandom_range(0, 1)));
    while (term_bits.size() != 0) begin
      for (int i = 7; i >= 0; i--) data[i] = term_bits.pop_front();
      send_byte(data);
    end
  endtask

  // Feed short variables until the decoder sits at the start of an entry.
  task automatic resync();
    while (dec_st.phase != PH_TAG0 || dec_st.pending != 1) send_byte(8'hAA);
  endtask

  task automatic wait_drained();
    bytes_if.valid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_entry_count(input logic [31:0] v);
    cfg_if.valid       <= 1'b1;
    cfg_if.entry_count <= v;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    entry_count_cfg = v;
    settings_used++;
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatches < MAX_PRINTED)
      $display("MISMATCH token %0d: %s got 0x%0h want 0x%0h", tokens_checked, what, got, want);
    mismatches++;
  endtask

  task automatic check_token();
    token_t want;
    if (expected_tokens.size() == 0) begin
      report_mismatch("unexpected token kind", tokens_if.token_kind, 0);
    end else begin
      want = expected_tokens.pop_front();
      if (tokens_if.token_kind !== want.kind)
        report_mismatch("token_kind", tokens_if.token_kind, want.kind);
      if (tokens_if.token_value !== want.value)
        report_mismatch("token_value", tokens_if.token_value, want.value);
      if (tokens_if.entry_done !== want.done)
        report_mismatch("entry_done", tokens_if.entry_done, want.done);
      if (tokens_if.entry_number !== want.entry_number)
        report_mismatch("entry_number", tokens_if.entry_number, want.entry_number);
      if (tokens_if.decode_error !== want.err)
        report_mismatch("decode_error", tokens_if.decode_error, want.err);
      if (tokens_if.last !== want.last)
        report_mismatch("last", tokens_if.last, want.last);
    end
    tokens_checked++;
  endtask

  // Token sink: check each beat, stall at random, honor a requested hold-off.
  always @(posedge clk) begin
    if (rst) begin
      tokens_if.ready <= 1'b0;
    end else begin
      if (tokens_if.valid && tokens_if.ready) check_token();
      if (hold_req != 0) begin
        stall_left = hold_req;
        hold_req <= 0;
      end
      if (stall_left > 0) begin
        tokens_if.ready <= 1'b0;
        stall_left--;
      end else begin
        tokens_if.ready <= 1'b1;
        if (idle_en && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (bytes_if.valid && bytes_if.ready) || (tokens_if.valid && tokens_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
      $display("status: fail");
      $finish;
    end
  end

  // ---------------- tests ----------------

  task automatic test_directed_terms();
    // Reference under the reset count of one entry: out of range.
    stage_ref(2'd0, 64'd0);
    send_staged();
    wait_drained();
    write_entry_count(32'd5);
    stage_abs(); stage_app(); stage_var(0); stage_var(1);
    send_staged();
    // In range at the top end, then one past it.
    stage_app(); stage_ref(2'd0, 64'd3); stage_ref(2'd1, 64'd4);
    send_staged();
    stage_ref(2'd2, 64'd2);
    send_staged();
    stage_ref(2'd3, 64'd0);
    send_staged();
    // Four tokens in the first byte.
    stage_app(); stage_app(); stage_var(0); stage_var(0); stage_var(0);
    send_staged();
  endtask

  task automatic test_entry_count_extremes();
    logic [31:0] counts [5];
    logic [63:0] ec;
    counts = '{32'd1, 32'd2, 32'd3, 32'hFFFF_FFFE, 32'hFFFF_FFFF};
    foreach (counts[i]) begin
      wait_drained();
      write_entry_count(counts[i]);
      ec = {32'd0, counts[i]};
      stage_ref(2'd0, 64'd0);               send_staged();
      stage_ref(2'd2, ec - 64'd2);          send_staged();
      stage_ref(2'd2, ec - 64'd1);          send_staged();
      stage_ref(2'd3, ec - 64'd2);          send_staged();
      stage_ref(2'd3, '1);                  send_staged();
      stage_ref(2'd1, 64'($urandom));       send_staged();
    end
  endtask

  task automatic test_long_variable();
    idle_en = 1'b0;
    // Runs of ones that span several bytes.
    repeat (VAR_RUN_BYTES) send_byte(8'hFF);
    send_byte(8'h00);
    repeat (VAR_RUN_BYTES + 1) send_byte(8'hFF);
    send_byte(8'h00);
    idle_en = 1'b1;
  endtask

  task automatic test_deep_nesting();
    idle_en = 1'b0;
    // Pile up applications, then close them all.
    repeat (APP_RUN_BYTES) send_byte(8'h00);
    resync();
    idle_en = 1'b1;
  endtask

  task automatic test_backpressure();
    idle_en = 1'b0;
    hold_req <= HOLD_CYCLES;
    repeat (12) send_byte(8'h00);
    resync();
    idle_en = 1'b1;
  endtask

  task automatic test_random_terms();
    int quota;
    int r;
    int cut;
    for (int p = 0; p < 4; p++) begin
      wait_drained();
      case (p)
        0: write_entry_count(32'($urandom_range(2, 40)));
        1: write_entry_count(32'hFFFF_FFFF);
        2: write_entry_count(32'd1);
        default: write_entry_count($urandom);
      endcase
      idle_en = (p != 1);
      quota = bytes_sent + RANDOM_BYTES / 4;
      while (bytes_sent < quota) begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          stage_random_term($urandom_range(1, 12));
          send_staged();
        end else if (r < 85) begin
          // Cut a term short and let the padding run on into the decoder.
          stage_random_term($urandom_range(1, 12));
          cut = $urandom_range(1, term_bits.size());
          while (term_bits.size() > cut) void'(term_bits.pop_back());
          send_staged();
          resync();
        end else begin
          repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
          resync();
        end
      end
    end
    idle_en = 1'b1;
  endtask

  initial begin
    rst                <= 1'b1;
    bytes_if.valid     <= 1'b0;
    bytes_if.data_byte <= 8'd0;
    cfg_if.valid       <= 1'b0;
    cfg_if.entry_count <= 32'd0;
    mismatches         = 0;
    tokens_checked     = 0;
    bytes_sent         = 0;
    settings_used      = 0;
    idle_en            = 1'b1;
    dec_st             = STATE_RESET;
    entry_count_cfg    = 32'd1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_terms();
    test_entry_count_extremes();
    test_long_variable();
    test_deep_nesting();
    test_backpressure();
    test_random_terms();
    wait_drained();

    $display("run covered %0d bytes, %0d tokens, %0d entries, %0d entry_count writes",
             bytes_sent, tokens_checked, dec_st.entry, settings_used);
    $display("with all reference widths, multi-byte variables, nesting and a %0d-cycle stall",
             HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("status: fail");
    end
    $finish;
  end

endmodule
